/* hw/rtl/tea_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants of the tractive energy accumulator: beat
// payloads, register indexes and the request and response groups of the
// serial divider and square root units.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int DivNumWidth  = 48;
    localparam int DivDenWidth  = 32;
    localparam int DivSteps     = DivNumWidth;
    localparam int SqrtRadWidth = 58;
    localparam int SqrtRootWidth = SqrtRadWidth / 2;
    localparam int CfgDataWidth = 20;

    localparam logic [19:0] MassReset  = 20'd24131;
    localparam logic [17:0] DragReset  = 18'd8847;
    localparam logic [15:0] RollReset  = 16'd3932;
    localparam logic [11:0] GravReset  = 12'd2511;
    localparam logic [15:0] LenReset   = 16'd1280;
    localparam logic [15:0] StepReset  = 16'd1280;
    localparam logic [16:0] UnitQ16    = 17'd65536;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [23:0] elevation;
        logic               last_point;
    } tea_point_t;

    typedef struct packed {
        logic signed [47:0] tractive_energy;
        logic               saturated;
    } tea_energy_t;

    typedef enum logic [2:0] {
        CFG_VEHICLE_MASS     = 3'd0,
        CFG_DRAG_FACTOR      = 3'd1,
        CFG_ROLL_COEFFICIENT = 3'd2,
        CFG_GRAVITY          = 3'd3,
        CFG_SEGMENT_LENGTH   = 3'd4,
        CFG_ACCEL_STEP       = 3'd5
    } tea_cfg_idx_t;

    typedef struct packed {
        logic                   start;
        logic [DivNumWidth-1:0] num;
        logic [DivDenWidth-1:0] den;
    } tea_div_req_t;

    typedef struct packed {
        logic                   done;
        logic [DivNumWidth-1:0] quo;
    } tea_div_rsp_t;

    typedef struct packed {
        logic                    start;
        logic [SqrtRadWidth-1:0] rad;
    } tea_sqrt_req_t;

    typedef struct packed {
        logic                     done;
        logic [SqrtRootWidth-1:0] root;
    } tea_sqrt_rsp_t;

endpackage

/* hw/rtl/tea_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// acceleration, sine and cosine quotients.
// ----------------------------------------------------------------------------
module tea_div
    import tea_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tea_div_req_t req,
    output tea_div_rsp_t rsp
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [5:0]             cnt_reg;
    logic [DivDenWidth-1:0] rem_reg;
    logic [DivNumWidth-1:0] work_reg;
    logic [DivDenWidth-1:0] den_reg;
    logic [DivDenWidth:0]   rem_shift;
    logic [DivDenWidth+1:0] diff;
    logic                   ge;

    assign rem_shift = {rem_reg, work_reg[DivNumWidth-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = !diff[DivDenWidth+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(DivSteps);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 6'd1;
            busy_reg <= (cnt_reg != 6'd1);
            done_reg <= (cnt_reg == 6'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            work_reg <= req.num;
            den_reg  <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DivDenWidth-1:0] : rem_shift[DivDenWidth-1:0];
            work_reg <= {work_reg[DivNumWidth-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = work_reg;

endmodule

/* hw/rtl/tea_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_sqrt
// Digit-by-digit integer square root, one root bit per cycle, for the
// slope hypotenuse.
// ----------------------------------------------------------------------------
module tea_sqrt
    import tea_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tea_sqrt_req_t req,
    output tea_sqrt_rsp_t rsp
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [4:0]               cnt_reg;
    logic [SqrtRadWidth-1:0]  rad_reg;
    logic [SqrtRootWidth-1:0] root_reg;
    logic [31:0]              rem_reg;
    logic [31:0]              rem_shift;
    logic [31:0]              trial;
    logic                     ge;

    assign rem_shift = {rem_reg[29:0], rad_reg[SqrtRadWidth-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign ge        = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(SqrtRootWidth);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            busy_reg <= (cnt_reg != 5'd1);
            done_reg <= (cnt_reg == 5'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.rad;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SqrtRadWidth-3:0], 2'b00};
            root_reg <= {root_reg[SqrtRootWidth-2:0], ge};
            rem_reg  <= ge ? (rem_shift - trial) : rem_shift;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

/* hw/rtl/tea_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_mul
// Shared 32 by 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tea_mul
    import tea_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

/* hw/rtl/tractive_energy_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tractive_energy_accumulator
// Road-load tractive energy over a run of route points, summed with
// saturation and emitted on the last point of the run.
//
//   channel  | direction | handshake          | payload
//   point    | in        | point_valid/stall  | tea_point_t
//   energy   | out       | energy_valid/stall | tea_energy_t
//   cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// A point with a predecessor runs a 48-bit division for the acceleration,
// a 29-bit square root and, if the root is nonzero, divisions for sine
// and cosine, between multiplier steps. A point with no predecessor goes
// straight to ST_FIN. point_stall is high while a point is in work.
// Reset restores the register defaults and clears the run state.
// A last point waits for the output register to be free.
// ----------------------------------------------------------------------------
module tractive_energy_accumulator
    import tea_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    point_valid,
    output logic                    point_stall,
    input  tea_point_t              point,
    output logic                    energy_valid,
    input  logic                    energy_stall,
    output tea_energy_t             energy,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    typedef enum logic [22:0] {
        ST_IDLE  = 23'h000001,
        ST_VA2   = 23'h000002,
        ST_VB2   = 23'h000004,
        ST_DV    = 23'h000008,
        ST_DIVA  = 23'h000010,
        ST_MLO   = 23'h000020,
        ST_MHI   = 23'h000040,
        ST_FI    = 23'h000080,
        ST_L2    = 23'h000100,
        ST_RAD   = 23'h000200,
        ST_SQ    = 23'h000400,
        ST_DSIN  = 23'h000800,
        ST_DCOS  = 23'h001000,
        ST_MG    = 23'h002000,
        ST_MSIN  = 23'h004000,
        ST_MCOS  = 23'h008000,
        ST_MROLL = 23'h010000,
        ST_MDRAG = 23'h020000,
        ST_SUMF  = 23'h040000,
        ST_ELO   = 23'h080000,
        ST_EHI   = 23'h100000,
        ST_ACC   = 23'h200000,
        ST_FIN   = 23'h400000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] mass_reg;
    logic [17:0] drag_reg;
    logic [15:0] roll_reg;
    logic [11:0] grav_reg;
    logic [15:0] len_reg;
    logic [15:0] step_reg;

    logic               have_prev_reg;
    logic [15:0]        prev_speed_reg;
    logic signed [23:0] prev_elev_reg;
    logic signed [47:0] sum_reg;
    logic               sat_reg;

    logic               out_valid_reg;
    tea_energy_t        out_data_reg;

    logic [15:0]        vb_reg;
    logic signed [23:0] eb_reg;
    logic               last_reg;
    logic [31:0]        va2_reg;
    logic               acc_neg_reg;
    logic [39:0]        acc_reg;
    logic [51:0]        plo_reg;
    logic signed [48:0] fi_reg;
    logic [47:0]        adh2_reg;
    logic [28:0]        hyp_reg;
    logic [16:0]        sin_reg;
    logic [16:0]        cos_reg;
    logic [31:0]        mg_reg;
    logic signed [29:0] fg_reg;
    logic [27:0]        fr_reg;
    logic signed [51:0] f_reg;
    logic [47:0]        elo_reg;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    tea_div_req_t  div_req;
    tea_div_rsp_t  div_rsp;
    tea_sqrt_req_t sqrt_req;
    tea_sqrt_rsp_t sqrt_rsp;

    logic signed [24:0] dh;
    logic [24:0]        adh_w;
    logic [23:0]        adh;
    logic signed [32:0] dv2;
    logic [32:0]        dv_mag_w;
    logic [15:0]        step_eff;
    logic [59:0]        fi_prod;
    logic signed [60:0] fi_val;
    logic signed [49:0] fg_val;
    logic signed [51:0] f_sum;
    logic [51:0]        f_mag;
    logic [67:0]        e_prod;
    logic signed [68:0] e_val;
    logic signed [63:0] total;
    logic [48:0]        rad_sum;
    logic [16:0]        div_clamp;
    logic               out_free;
    logic               cfg_write;
    logic               fin_go;

    tea_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tea_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tea_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign dh       = 25'(eb_reg) - 25'(prev_elev_reg);
    assign adh_w    = dh[24] ? 25'(-dh) : 25'(dh);
    assign adh      = adh_w[23:0];
    assign dv2      = $signed({1'b0, mul_p[31:0]}) - $signed({1'b0, va2_reg});
    assign dv_mag_w = dv2[32] ? 33'(-dv2) : 33'(dv2);
    assign step_eff = (step_reg == 16'd0) ? 16'd1 : step_reg;

    assign fi_prod = {8'd0, plo_reg} + {mul_p[27:0], 32'd0};
    assign fi_val  = acc_neg_reg ? -$signed({1'b0, fi_prod}) : $signed({1'b0, fi_prod});
    assign fg_val  = dh[24] ? -$signed({1'b0, mul_p[48:0]}) : $signed({1'b0, mul_p[48:0]});
    assign f_sum   = 52'(fi_reg) + 52'(fg_reg) + $signed({24'd0, fr_reg})
                   + $signed({26'd0, mul_p[49:24]});
    assign f_mag   = f_reg[51] ? 52'(-f_reg) : 52'(f_reg);
    assign e_prod  = {20'd0, elo_reg} + {mul_p[35:0], 32'd0};
    assign e_val   = f_reg[51] ? -$signed({1'b0, e_prod}) : $signed({1'b0, e_prod});
    assign total   = 64'(sum_reg) + 64'($signed(e_val[68:8]));
    assign rad_sum = {1'b0, adh2_reg} + {17'd0, mul_p[31:0]};
    assign div_clamp = (div_rsp.quo > 48'(UnitQ16)) ? UnitQ16 : div_rsp.quo[16:0];

    assign out_free  = !out_valid_reg || !energy_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign fin_go    = (state_reg == ST_FIN) && (!last_reg || out_free);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_VA2:   begin mul_a = 32'(prev_speed_reg); mul_b = 32'(prev_speed_reg); end
            ST_VB2:   begin mul_a = 32'(vb_reg);         mul_b = 32'(vb_reg);         end
            ST_MLO:   begin mul_a = 32'(mass_reg);       mul_b = acc_reg[31:0];       end
            ST_MHI:   begin mul_a = 32'(mass_reg);       mul_b = 32'(acc_reg[39:32]); end
            ST_FI:    begin mul_a = 32'(adh);            mul_b = 32'(adh);            end
            ST_L2:    begin mul_a = 32'(len_reg);        mul_b = 32'(len_reg);        end
            ST_MG:    begin mul_a = 32'(mass_reg);       mul_b = 32'(grav_reg);       end
            ST_MSIN:  begin mul_a = mul_p[31:0];         mul_b = 32'(sin_reg);        end
            ST_MCOS:  begin mul_a = mg_reg;              mul_b = 32'(cos_reg);        end
            ST_MROLL: begin mul_a = mul_p[47:16];        mul_b = 32'(roll_reg);       end
            ST_MDRAG: begin mul_a = 32'(drag_reg);       mul_b = va2_reg;             end
            ST_ELO:   begin mul_a = f_mag[31:0];         mul_b = 32'(len_reg);        end
            ST_EHI:   begin mul_a = 32'(f_mag[51:32]);   mul_b = 32'(len_reg);        end
            default:  begin mul_a = '0;                  mul_b = '0;                  end
        endcase
    end

    always_comb
    begin
        div_req       = '0;
        sqrt_req      = '0;
        sqrt_req.rad  = {1'b0, rad_sum, 8'd0};
        unique case (state_reg)
            ST_DV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {8'd0, dv_mag_w[31:0], 8'd0};
                div_req.den   = {15'd0, step_eff, 1'b0};
            end
            ST_RAD:
            begin
                sqrt_req.start = 1'b1;
            end
            ST_SQ:
            begin
                div_req.start = sqrt_rsp.done && (sqrt_rsp.root != '0);
                div_req.num   = {4'd0, adh, 20'd0};
                div_req.den   = {3'd0, sqrt_rsp.root};
            end
            ST_DSIN:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = {12'd0, len_reg, 20'd0};
                div_req.den   = {3'd0, hyp_reg};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = have_prev_reg ? ST_VA2 : ST_FIN;
                end
            end
            ST_VA2:   state_next = ST_VB2;
            ST_VB2:   state_next = ST_DV;
            ST_DV:    state_next = ST_DIVA;
            ST_DIVA:  state_next = div_rsp.done ? ST_MLO : ST_DIVA;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_FI;
            ST_FI:    state_next = ST_L2;
            ST_L2:    state_next = ST_RAD;
            ST_RAD:   state_next = ST_SQ;
            ST_SQ:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = (sqrt_rsp.root == '0) ? ST_MG : ST_DSIN;
                end
            end
            ST_DSIN:  state_next = div_rsp.done ? ST_DCOS : ST_DSIN;
            ST_DCOS:  state_next = div_rsp.done ? ST_MG : ST_DCOS;
            ST_MG:    state_next = ST_MSIN;
            ST_MSIN:  state_next = ST_MCOS;
            ST_MCOS:  state_next = ST_MROLL;
            ST_MROLL: state_next = ST_MDRAG;
            ST_MDRAG: state_next = ST_SUMF;
            ST_SUMF:  state_next = ST_ELO;
            ST_ELO:   state_next = ST_EHI;
            ST_EHI:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_FIN;
            ST_FIN:   state_next = fin_go ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mass_reg       <= MassReset;
            drag_reg       <= DragReset;
            roll_reg       <= RollReset;
            grav_reg       <= GravReset;
            len_reg        <= LenReset;
            step_reg       <= StepReset;
            have_prev_reg  <= 1'b0;
            prev_speed_reg <= '0;
            prev_elev_reg  <= '0;
            sum_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_VEHICLE_MASS:     mass_reg <= cfg_data[19:0];
                    CFG_DRAG_FACTOR:      drag_reg <= cfg_data[17:0];
                    CFG_ROLL_COEFFICIENT: roll_reg <= cfg_data[15:0];
                    CFG_GRAVITY:          grav_reg <= cfg_data[11:0];
                    CFG_SEGMENT_LENGTH:   len_reg  <= cfg_data[15:0];
                    CFG_ACCEL_STEP:       step_reg <= cfg_data[15:0];
                    default:              mass_reg <= mass_reg;
                endcase
            end
            if (state_reg == ST_ACC)
            begin
                if (total > 64'sh0000_7FFF_FFFF_FFFF)
                begin
                    sum_reg <= 48'sh7FFF_FFFF_FFFF;
                    sat_reg <= 1'b1;
                end
                else if (total < -64'sh0000_8000_0000_0000)
                begin
                    sum_reg <= 48'sh8000_0000_0000;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= total[47:0];
                end
            end
            if (fin_go)
            begin
                if (last_reg)
                begin
                    have_prev_reg  <= 1'b0;
                    prev_speed_reg <= '0;
                    prev_elev_reg  <= '0;
                    sum_reg        <= '0;
                    sat_reg        <= 1'b0;
                end
                else
                begin
                    have_prev_reg  <= 1'b1;
                    prev_speed_reg <= vb_reg;
                    prev_elev_reg  <= eb_reg;
                end
            end
            if (fin_go && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!energy_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go && last_reg)
        begin
            out_data_reg.tractive_energy <= sum_reg;
            out_data_reg.saturated       <= sat_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                vb_reg   <= point.speed;
                eb_reg   <= point.elevation;
                last_reg <= point.last_point;
            end
            ST_VB2:  va2_reg <= mul_p[31:0];
            ST_DV:   acc_neg_reg <= dv2[32];
            ST_DIVA: acc_reg <= div_rsp.quo[39:0];
            ST_MHI:  plo_reg <= mul_p[51:0];
            ST_FI:   fi_reg  <= fi_val[60:12];
            ST_L2:   adh2_reg <= mul_p[47:0];
            ST_SQ:
            begin
                hyp_reg <= sqrt_rsp.root;
                sin_reg <= '0;
                cos_reg <= UnitQ16;
            end
            ST_DSIN: sin_reg <= div_clamp;
            ST_DCOS: cos_reg <= div_clamp;
            ST_MSIN: mg_reg  <= mul_p[31:0];
            ST_MCOS: fg_reg  <= fg_val[49:20];
            ST_MDRAG: fr_reg <= mul_p[47:20];
            ST_SUMF: f_reg   <= f_sum;
            ST_EHI:  elo_reg <= mul_p[47:0];
            default: elo_reg <= elo_reg;
        endcase
    end

    assign point_stall  = (state_reg != ST_IDLE);
    assign energy_valid = out_valid_reg;
    assign energy       = out_data_reg;

endmodule

/* hw/rtl/tea_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_checker
// Port-level checks of the tractive energy accumulator, bound to the top.
// ----------------------------------------------------------------------------
module tea_checker
    import tea_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    point_valid,
    input logic                    point_stall,
    input tea_point_t              point,
    input logic                    energy_valid,
    input logic                    energy_stall,
    input tea_energy_t             energy,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [2:0]              cfg_index,
    input logic [CfgDataWidth-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        energy_valid && energy_stall |=> energy_valid)
        else $error("energy beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        energy_valid && energy_stall |=> $stable(energy))
        else $error("energy beat changed while stalled");

    a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> point_stall)
        else $error("point accepted without entering work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(energy_valid) |-> $past(point_stall))
        else $error("energy beat without a point in work");

endmodule

bind tractive_energy_accumulator tea_checker u_tea_checker (.*);

/* tb/tea_energy_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_energy_checker
// Watches the point, energy and register channels of the tractive energy
// accumulator, predicts the run energy of every last point and compares
// each emitted energy beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module tea_energy_checker
    import tea_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    point_valid,
    input  logic                    point_stall,
    input  tea_point_t              point,
    input  logic                    energy_valid,
    input  logic                    energy_stall,
    input  tea_energy_t             energy,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output int                      fail_count,
    output int                      pending_count,
    output int                      energy_beats
);

    localparam longint EnergyMax = 64'sd140737488355327;
    localparam longint EnergyMin = -64'sd140737488355328;

    logic [19:0] mass_r;
    logic [17:0] drag_r;
    logic [15:0] roll_r;
    logic [11:0] grav_r;
    logic [15:0] len_r;
    logic [15:0] step_r;

    logic [15:0] prev_speed;
    longint      prev_elev;
    logic        have_prev;
    longint      run_energy;
    logic        run_sat;

    tea_energy_t expected_energy_q[$];

    function automatic longint floor_div_pow2(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint segment_energy(longint va, longint vb, longint ea, longint eb);
        longint m, l, st, dv2, acc, fi, dh, adh, hyp, sn, cs, mg, fg, fr, fd, f, fh, fl;
        m   = mass_r;
        l   = len_r;
        st  = (step_r == 0) ? 1 : step_r;
        dv2 = vb * vb - va * va;
        acc = (dv2 * 256) / (2 * st);
        fi  = floor_div_pow2(m * acc, 12);
        dh  = eb - ea;
        adh = (dh < 0) ? -dh : dh;
        hyp = int_sqrt((adh * adh + l * l) << 8);
        sn  = 0;
        cs  = 65536;
        if (hyp != 0)
        begin
            sn = (dh * 1048576) / hyp;
            if (sn > 65536) sn = 65536;
            if (sn < -65536) sn = -65536;
            cs = (l * 1048576) / hyp;
            if (cs > 65536) cs = 65536;
        end
        mg = m * longint'(grav_r);
        fg = floor_div_pow2(mg * sn, 20);
        fr = (((mg * cs) >> 16) * longint'(roll_r)) >> 20;
        fd = (longint'(drag_r) * va * va) >> 24;
        f  = fi + fg + fr + fd;
        fh = floor_div_pow2(f, 8);
        fl = f - fh * 256;
        return fh * l + ((fl * l) >> 8);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint s;
        tea_energy_t exp_beat;
        if (!rst_n)
        begin
            mass_r = MassReset;
            drag_r = DragReset;
            roll_r = RollReset;
            grav_r = GravReset;
            len_r  = LenReset;
            step_r = StepReset;
            prev_speed = '0;
            prev_elev  = 0;
            have_prev  = 1'b0;
            run_energy = 0;
            run_sat    = 1'b0;
            fail_count = 0;
            energy_beats = 0;
            expected_energy_q.delete();
        end
        else
        begin
            if (energy_valid && !energy_stall)
            begin
                energy_beats++;
                if (expected_energy_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("energy beat with none expected: %0d sat %0b",
                                 energy.tractive_energy, energy.saturated);
                end
                else
                begin
                    exp_beat = expected_energy_q.pop_front();
                    if (exp_beat.tractive_energy !== energy.tractive_energy
                        || exp_beat.saturated !== energy.saturated)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("energy mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     exp_beat.tractive_energy, exp_beat.saturated,
                                     energy.tractive_energy, energy.saturated);
                    end
                end
            end
            if (point_valid && !point_stall)
            begin
                if (have_prev)
                begin
                    s = run_energy + segment_energy(prev_speed, point.speed,
                                                    prev_elev, point.elevation);
                    if (s > EnergyMax)
                    begin
                        s = EnergyMax;
                        run_sat = 1'b1;
                    end
                    if (s < EnergyMin)
                    begin
                        s = EnergyMin;
                        run_sat = 1'b1;
                    end
                    run_energy = s;
                end
                prev_speed = point.speed;
                prev_elev  = point.elevation;
                have_prev  = 1'b1;
                if (point.last_point)
                begin
                    exp_beat.tractive_energy = run_energy[47:0];
                    exp_beat.saturated = run_sat;
                    expected_energy_q.push_back(exp_beat);
                    prev_speed = '0;
                    prev_elev  = 0;
                    have_prev  = 1'b0;
                    run_energy = 0;
                    run_sat    = 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VEHICLE_MASS:     mass_r = cfg_data[19:0];
                    CFG_DRAG_FACTOR:      drag_r = cfg_data[17:0];
                    CFG_ROLL_COEFFICIENT: roll_r = cfg_data[15:0];
                    CFG_GRAVITY:          grav_r = cfg_data[11:0];
                    CFG_SEGMENT_LENGTH:   len_r  = cfg_data[15:0];
                    CFG_ACCEL_STEP:       step_r = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_energy_q.size();
    end

endmodule

/* tb/tb_tractive_energy_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tractive_energy_accumulator
// Drives route points and register writes into the tractive energy
// accumulator under several idle and stall mixes; the checker predicts and
// compares every energy beat, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_tractive_energy_accumulator;
    import tea_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    point_valid;
    logic                    point_stall;
    tea_point_t              point;
    logic                    energy_valid;
    logic                    energy_stall;
    tea_energy_t             energy;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;
    int                      fail_count;
    int                      pending_count;
    int                      energy_beats;
    int                      idle_pct;
    int                      stall_pct;
    int                      points_sent;

    tractive_energy_accumulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .energy_valid (energy_valid),
        .energy_stall (energy_stall),
        .energy       (energy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tea_energy_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .point         (point),
        .energy_valid  (energy_valid),
        .energy_stall  (energy_stall),
        .energy        (energy),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .energy_beats  (energy_beats)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        energy_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_point(input logic [15:0] spd, input logic [23:0] elev,
                              input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point.speed <= spd;
        point.elevation <= elev;
        point.last_point <= lst;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic write_register(input tea_cfg_idx_t idx, input logic [19:0] val);
        point_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [19:0] m, input logic [19:0] d,
                             input logic [19:0] r, input logic [19:0] g,
                             input logic [19:0] l, input logic [19:0] s);
        write_register(CFG_VEHICLE_MASS, m);
        write_register(CFG_DRAG_FACTOR, d);
        write_register(CFG_ROLL_COEFFICIENT, r);
        write_register(CFG_GRAVITY, g);
        write_register(CFG_SEGMENT_LENGTH, l);
        write_register(CFG_ACCEL_STEP, s);
    endtask

    task automatic random_run(input int npts, input int elev_span);
        logic [15:0] spd;
        logic [23:0] elev;
        spd  = 16'($urandom);
        elev = 24'($urandom);
        for (int i = 0; i < npts; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                spd  = 16'($urandom);
                elev = 24'($urandom);
            end
            else
            begin
                spd  = spd + 16'($urandom_range(1024)) - 16'd512;
                elev = elev + 24'($urandom_range(2 * elev_span)) - 24'(elev_span);
            end
            send_point(spd, elev, i == npts - 1);
        end
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(12, 1);
            random_run(len, ($urandom_range(3) == 0) ? 4000000 : 2000);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VEHICLE_MASS;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        points_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(16'd0, 24'd0, 1'b1);
        send_point(16'd0, 24'h800000, 1'b0);
        send_point(16'hFFFF, 24'h7FFFFF, 1'b1);
        send_point(16'hFFFF, 24'h7FFFFF, 1'b0);
        send_point(16'd0, 24'h800000, 1'b1);
        send_point(16'd5000, 24'd100, 1'b0);
        send_point(16'd5200, 24'd100, 1'b0);
        send_point(16'd5300, 24'hFFFF00, 1'b0);
        send_point(16'd5000, 24'd0, 1'b1);

        write_all(20'hFFFFF, 20'h3FFFF, 20'hFFFF, 20'hFFF, 20'hFFFF, 20'hFFFF);
        for (int i = 0; i < 4; i++)
        begin
            send_point(16'd0, (i % 2) ? 24'h800000 : 24'h7FFFFF, 1'b0);
            send_point(16'hFFFF, (i % 2) ? 24'h7FFFFF : 24'h800000, 1'b0);
        end
        send_point(16'hFFFF, 24'h7FFFFF, 1'b1);

        write_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        send_point(16'd100, 24'd5, 1'b0);
        send_point(16'd9000, 24'd5, 1'b0);
        send_point(16'd200, 24'd7, 1'b1);
        write_all(20'd16000, 20'd9000, 20'd4000, 20'd2511, 20'd1, 20'd1);
        send_point(16'd300, 24'd0, 1'b0);
        send_point(16'd60000, 24'd400, 1'b1);

        write_all(MassReset, DragReset, RollReset, GravReset, LenReset, StepReset);
        random_phase(200);
        idle_pct = 57;
        random_phase(200);
        write_all(20'($urandom_range(1048575)), 20'($urandom_range(262143)),
                  20'($urandom_range(65535)), 20'($urandom_range(4095)),
                  20'($urandom_range(65535, 1)), 20'($urandom_range(65535, 1)));
        idle_pct = 0;
        stall_pct = 57;
        random_phase(200);
        write_all(MassReset, DragReset, RollReset, GravReset, LenReset, StepReset);
        idle_pct = 23;
        stall_pct = 23;
        random_phase(250);

        point_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered %0d points and %0d energy beats over four idle/stall mixes",
                 points_sent, energy_beats);
        $display("with directed field extremes and seven register settings.");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* tractive_energy_accumulator.f */
hw/rtl/tea_pkg.sv
hw/rtl/tea_div.sv
hw/rtl/tea_sqrt.sv
hw/rtl/tea_mul.sv
hw/rtl/tractive_energy_accumulator.sv
hw/rtl/tea_checker.sv
tb/tea_energy_checker.sv
tb/tb_tractive_energy_accumulator.sv
